// ===== hdl/rk4tb_pkg.sv =====
// Shared constants, unit request/response types and saturation helper for the RK4 propagator.
package rk4tb_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_STEPS = 64;
	localparam int MUL_STEPS = 32;
	localparam int DIV_STEPS = 64;
	localparam int SQRT_STEPS = 32;
	localparam int SIXTH_DIV = 6;

	localparam logic [1:0] REG_SUN_X = 2'd0;
	localparam logic [1:0] REG_SUN_Y = 2'd1;
	localparam logic [1:0] REG_GRAVITY = 2'd2;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [95:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] nhi;
		logic [63:0] nlo;
		logic [63:0] d;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] q;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] v;
	} sqrt_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] r;
	} sqrt_rsp_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		if (v > 50'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -50'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

// ===== hdl/rk4tb_mul.sv =====
// Shift-add multiplier, 64 x 32 bits to 96 bits, one multiplier bit per cycle.
module rk4tb_mul import rk4tb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int CW = $clog2(MUL_STEPS);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [95:0]   acc_q;
	logic [95:0]   a_q;
	logic [31:0]   b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q <= 96'(req.a);
			b_q <= req.b;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p = acc_q;

endmodule

// ===== hdl/rk4tb_div.sv =====
// Restoring divider, 128 / 64 bits to a 64-bit quotient, saturated to all ones on overflow.
module rk4tb_div import rk4tb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(DIV_STEPS);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]   rem_q;
	logic [63:0]   lo_q;
	logic [63:0]   q_q;
	logic [63:0]   d_q;
	logic          ovf;
	logic [64:0]   sh;
	logic          ge;
	logic [63:0]   rem_next;

	assign ovf = req.nhi >= req.d;

	always_comb begin
		sh = {rem_q, lo_q[63]};
		ge = sh[64] | (sh[63:0] >= d_q);
		rem_next = ge ? (sh[63:0] - d_q) : sh[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.nhi;
			lo_q <= req.nlo;
			d_q <= req.d;
			q_q <= ovf ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			lo_q <= lo_q << 1;
			q_q <= {q_q[62:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.q = q_q;

endmodule

// ===== hdl/rk4tb_sqrt.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
module rk4tb_sqrt import rk4tb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	localparam int CW = $clog2(SQRT_STEPS);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]   v_q;
	logic [63:0]   res_q;
	logic [63:0]   bit_q;
	logic [63:0]   trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// leading steps with bit above v leave res at zero, so no start search is needed
	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q <= req.v;
			res_q <= '0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.r = res_q[31:0];

endmodule

// ===== hdl/rk4_two_body_propagator.sv =====
// Top level: RK4 step sequencer driving the shared multiplier, divider and square root units.
//
// One transaction at start (with busy low) runs step_count RK4 steps (0 acts as 1, above 64 as
// 64) and puts one position per step on pos_x/pos_y for a single cycle with valid high; the
// receiver cannot stall and must take each result as it appears. busy stays high from the
// accepted transaction until the cycle in which the last result is shown. Setup is two passes
// of the divider, then each step is four acceleration evaluations (four multiplies, three
// divides and one square root each) plus sixteen scaled adds, all run one after another
// through the single bit-serial multiplier and divider. Configuration writes on wr_en take
// effect at once and belong only between transactions.
module rk4_two_body_propagator import rk4tb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [1:0]         wr_index,
	input  logic [47:0]        wr_data,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_vx,
	input  logic signed [31:0] start_vy,
	input  logic [31:0]        flight_time,
	input  logic [6:0]         step_count,
	output logic               valid,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [5:0]         step_index,
	output logic               last
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DT_W     = 4'd1;
	localparam logic [3:0] S_SIX_W    = 4'd2;
	localparam logic [3:0] S_AC_START = 4'd3;
	localparam logic [3:0] S_AC_SQX   = 4'd4;
	localparam logic [3:0] S_AC_SQY   = 4'd5;
	localparam logic [3:0] S_AC_SQRT  = 4'd6;
	localparam logic [3:0] S_AC_G     = 4'd7;
	localparam logic [3:0] S_AC_MX    = 4'd8;
	localparam logic [3:0] S_AC_DX    = 4'd9;
	localparam logic [3:0] S_AC_MY    = 4'd10;
	localparam logic [3:0] S_AC_DY    = 4'd11;
	localparam logic [3:0] S_UPD      = 4'd12;
	localparam logic [3:0] S_SC_ISSUE = 4'd13;
	localparam logic [3:0] S_SC_W     = 4'd14;
	localparam logic [3:0] S_EMIT     = 4'd15;

	logic [3:0] state_q;
	logic [1:0] k_q;
	logic [1:0] j_q;
	logic [5:0] i_q;
	logic       valid_q;

	logic signed [31:0] sun_x_q, sun_y_q;
	logic [47:0]        mu_q;

	logic signed [31:0] px_q, py_q, vx_q, vy_q;
	logic signed [31:0] ex_q, ey_q, eu_q, ew_q;
	logic signed [31:0] ax_q, ay_q;
	logic signed [35:0] sx_q, sy_q, svx_q, svy_q;
	logic [31:0]        dt_q, half_q, sixth_q;
	logic [6:0]         n_q;
	logic [31:0]        mx_q, my_q;
	logic               dxn_q, dyn_q;
	logic [63:0]        r2_q;
	logic [31:0]        r_q;
	logic [63:0]        g_q;

	logic signed [31:0] pos_x_q, pos_y_q;
	logic [5:0]         step_index_q;
	logic               last_q;

	mul_req_t  mul_req;
	mul_rsp_t  mul_rsp;
	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sqrt_req;
	sqrt_rsp_t sqrt_rsp;

	logic               accept;
	logic [6:0]         n_sat;
	logic signed [32:0] dx_w, dy_w;
	logic signed [31:0] dx_s, dy_s;
	logic [31:0]        dx_m, dy_m;
	logic [63:0]        r2n;
	logic [127:0]       num_w;
	logic               last_w;
	logic signed [35:0] sc_v;
	logic signed [31:0] sc_base;
	logic [31:0]        sc_t;
	logic               sc_neg;
	logic [35:0]        sc_mag;
	logic [47:0]        sc_m;
	logic signed [49:0] sc_sum;
	logic signed [31:0] sc_res;
	logic               wt2;
	logic signed [35:0] eu36, ew36, ax36, ay36;

	function automatic logic signed [31:0] accel_comp(input logic [63:0] q, input logic neg);
		logic [31:0] m;
		m = (q > 64'h7fffffff) ? 32'h7fffffff : q[31:0];
		return neg ? -$signed(m) : $signed(m);
	endfunction

	rk4tb_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	rk4tb_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	rk4tb_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .req(sqrt_req), .rsp(sqrt_rsp));

	assign busy = state_q != S_IDLE;
	assign accept = start && !busy;

	always_comb begin
		if (step_count == 7'd0) begin
			n_sat = 7'd1;
		end else if (step_count > 7'(MAX_STEPS)) begin
			n_sat = 7'(MAX_STEPS);
		end else begin
			n_sat = step_count;
		end
	end

	always_comb begin
		dx_w = {sun_x_q[31], sun_x_q} - {ex_q[31], ex_q};
		dy_w = {sun_y_q[31], sun_y_q} - {ey_q[31], ey_q};
		dx_s = sat32(50'(dx_w));
		dy_s = sat32(50'(dy_w));
		dx_m = dx_s[31] ? 32'(-dx_s) : 32'(dx_s);
		dy_m = dy_s[31] ? 32'(-dy_s) : 32'(dy_s);
	end

	assign r2n = r2_q + mul_rsp.p[63:0];
	assign num_w = 128'(mu_q) << (2 * FRAC_BITS);
	assign last_w = (7'(i_q) + 7'd1) == n_q;

	// scaled add: base + v * t, truncated toward zero, saturated
	always_comb begin
		if (k_q == 2'd3) begin
			case (j_q)
				2'd0: sc_v = sx_q;
				2'd1: sc_v = sy_q;
				2'd2: sc_v = svx_q;
				default: sc_v = svy_q;
			endcase
		end else begin
			case (j_q)
				2'd0: sc_v = 36'(eu_q);
				2'd1: sc_v = 36'(ew_q);
				2'd2: sc_v = 36'(ax_q);
				default: sc_v = 36'(ay_q);
			endcase
		end
		case (j_q)
			2'd0: sc_base = px_q;
			2'd1: sc_base = py_q;
			2'd2: sc_base = vx_q;
			default: sc_base = vy_q;
		endcase
		case (k_q)
			2'd3: sc_t = sixth_q;
			2'd2: sc_t = dt_q;
			default: sc_t = half_q;
		endcase
		sc_neg = sc_v[35];
		sc_mag = sc_neg ? 36'(-sc_v) : 36'(sc_v);
		sc_m = mul_rsp.p[FRAC_BITS+47:FRAC_BITS];
		sc_sum = 50'(sc_base) + (sc_neg ? -$signed({2'b00, sc_m}) : $signed({2'b00, sc_m}));
		sc_res = sat32(sc_sum);
	end

	always_comb begin
		wt2 = (k_q == 2'd1) || (k_q == 2'd2);
		eu36 = 36'(eu_q);
		ew36 = 36'(ew_q);
		ax36 = 36'(ax_q);
		ay36 = 36'(ay_q);
	end

	// unit requests
	always_comb begin
		mul_req = '0;
		div_req = '0;
		sqrt_req = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					div_req.start = 1'b1;
					div_req.nlo = 64'(flight_time);
					div_req.d = 64'(n_sat);
				end
			end
			S_DT_W: begin
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					div_req.nlo = 64'(div_rsp.q[31:0]);
					div_req.d = 64'(SIXTH_DIV);
				end
			end
			S_AC_START: begin
				mul_req.start = 1'b1;
				mul_req.a = 64'(dx_m);
				mul_req.b = dx_m;
			end
			S_AC_SQX: begin
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a = 64'(my_q);
					mul_req.b = my_q;
				end
			end
			S_AC_SQY: begin
				if (mul_rsp.done && r2n != 64'd0) begin
					sqrt_req.start = 1'b1;
					sqrt_req.v = r2n;
				end
			end
			S_AC_SQRT: begin
				if (sqrt_rsp.done) begin
					div_req.start = 1'b1;
					div_req.nhi = num_w[127:64];
					div_req.nlo = num_w[63:0];
					div_req.d = r2_q;
				end
			end
			S_AC_G: begin
				if (div_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a = div_rsp.q;
					mul_req.b = mx_q;
				end
			end
			S_AC_MX, S_AC_MY: begin
				if (mul_rsp.done) begin
					div_req.start = 1'b1;
					div_req.nhi = 64'(mul_rsp.p[95:64]);
					div_req.nlo = mul_rsp.p[63:0];
					div_req.d = 64'(r_q);
				end
			end
			S_AC_DX: begin
				if (div_rsp.done) begin
					mul_req.start = 1'b1;
					mul_req.a = g_q;
					mul_req.b = my_q;
				end
			end
			S_SC_ISSUE: begin
				mul_req.start = 1'b1;
				mul_req.a = 64'(sc_mag);
				mul_req.b = sc_t;
			end
			default: begin
			end
		endcase
	end

	// sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			j_q <= '0;
			i_q <= '0;
			valid_q <= 1'b0;
			sun_x_q <= '0;
			sun_y_q <= '0;
			mu_q <= 48'd1 << FRAC_BITS;
		end else begin
			valid_q <= 1'b0;
			if (wr_en) begin
				case (wr_index)
					REG_SUN_X: sun_x_q <= wr_data[31:0];
					REG_SUN_Y: sun_y_q <= wr_data[31:0];
					REG_GRAVITY: mu_q <= wr_data;
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						i_q <= '0;
						state_q <= S_DT_W;
					end
				end
				S_DT_W: if (div_rsp.done) state_q <= S_SIX_W;
				S_SIX_W: begin
					if (div_rsp.done) begin
						k_q <= '0;
						state_q <= S_AC_START;
					end
				end
				S_AC_START: state_q <= S_AC_SQX;
				S_AC_SQX: if (mul_rsp.done) state_q <= S_AC_SQY;
				S_AC_SQY: begin
					if (mul_rsp.done) begin
						state_q <= (r2n == 64'd0) ? S_UPD : S_AC_SQRT;
					end
				end
				S_AC_SQRT: if (sqrt_rsp.done) state_q <= S_AC_G;
				S_AC_G: if (div_rsp.done) state_q <= S_AC_MX;
				S_AC_MX: if (mul_rsp.done) state_q <= S_AC_DX;
				S_AC_DX: if (div_rsp.done) state_q <= S_AC_MY;
				S_AC_MY: if (mul_rsp.done) state_q <= S_AC_DY;
				S_AC_DY: if (div_rsp.done) state_q <= S_UPD;
				S_UPD: begin
					j_q <= '0;
					state_q <= S_SC_ISSUE;
				end
				S_SC_ISSUE: state_q <= S_SC_W;
				S_SC_W: begin
					if (mul_rsp.done) begin
						if (j_q == 2'd3) begin
							if (k_q == 2'd3) begin
								state_q <= S_EMIT;
							end else begin
								k_q <= k_q + 2'd1;
								state_q <= S_AC_START;
							end
						end else begin
							j_q <= j_q + 2'd1;
							state_q <= S_SC_ISSUE;
						end
					end
				end
				S_EMIT: begin
					valid_q <= 1'b1;
					if (last_w) begin
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 6'd1;
						k_q <= '0;
						state_q <= S_AC_START;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					px_q <= start_x;
					py_q <= start_y;
					vx_q <= start_vx;
					vy_q <= start_vy;
					n_q <= n_sat;
				end
			end
			S_DT_W: begin
				if (div_rsp.done) begin
					dt_q <= div_rsp.q[31:0];
					half_q <= {1'b0, div_rsp.q[31:1]};
				end
			end
			S_SIX_W: begin
				if (div_rsp.done) begin
					sixth_q <= div_rsp.q[31:0];
					ex_q <= px_q;
					ey_q <= py_q;
					eu_q <= vx_q;
					ew_q <= vy_q;
				end
			end
			S_AC_START: begin
				mx_q <= dx_m;
				my_q <= dy_m;
				dxn_q <= dx_s[31];
				dyn_q <= dy_s[31];
			end
			S_AC_SQX: if (mul_rsp.done) r2_q <= mul_rsp.p[63:0];
			S_AC_SQY: begin
				if (mul_rsp.done) begin
					r2_q <= r2n;
					if (r2n == 64'd0) begin
						ax_q <= '0;
						ay_q <= '0;
					end
				end
			end
			S_AC_SQRT: if (sqrt_rsp.done) r_q <= sqrt_rsp.r;
			S_AC_G: if (div_rsp.done) g_q <= div_rsp.q;
			S_AC_DX: if (div_rsp.done) ax_q <= accel_comp(div_rsp.q, dxn_q);
			S_AC_DY: if (div_rsp.done) ay_q <= accel_comp(div_rsp.q, dyn_q);
			S_UPD: begin
				// k1 + 2 k2 + 2 k3 + k4, kept wide
				if (k_q == 2'd0) begin
					sx_q <= eu36;
					sy_q <= ew36;
					svx_q <= ax36;
					svy_q <= ay36;
				end else begin
					sx_q <= sx_q + (wt2 ? (eu36 <<< 1) : eu36);
					sy_q <= sy_q + (wt2 ? (ew36 <<< 1) : ew36);
					svx_q <= svx_q + (wt2 ? (ax36 <<< 1) : ax36);
					svy_q <= svy_q + (wt2 ? (ay36 <<< 1) : ay36);
				end
			end
			S_SC_W: begin
				if (mul_rsp.done) begin
					if (k_q == 2'd3) begin
						case (j_q)
							2'd0: px_q <= sc_res;
							2'd1: py_q <= sc_res;
							2'd2: vx_q <= sc_res;
							default: vy_q <= sc_res;
						endcase
					end else begin
						case (j_q)
							2'd0: ex_q <= sc_res;
							2'd1: ey_q <= sc_res;
							2'd2: eu_q <= sc_res;
							default: ew_q <= sc_res;
						endcase
					end
				end
			end
			S_EMIT: begin
				pos_x_q <= px_q;
				pos_y_q <= py_q;
				step_index_q <= i_q;
				last_q <= last_w;
				ex_q <= px_q;
				ey_q <= py_q;
				eu_q <= vx_q;
				ew_q <= vy_q;
			end
			default: begin
			end
		endcase
	end

	assign valid = valid_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign step_index = step_index_q;
	assign last = last_q;

	a_valid_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result strobe without a running transaction");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after accepted transaction");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |-> !busy)
		else $error("still busy after final result");

	a_step_order: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |=> !valid)
		else $error("back-to-back results within one run");

endmodule
